@@ rtl/core/ierb_pkg.sv @@
// Shared constants and codes for the ICMP echo request builder.
package ierb_pkg;

  // Field widths of the request and result channels.
  localparam int SEQ_W    = 16;
  localparam int BYTE_W   = 8;
  localparam int OFFSET_W = 11;
  localparam int LIMIT_W  = 12;
  localparam int SUM_W    = 16;

  // Configuration port geometry.
  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 3;

  // Request opcodes.
  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  // Register indexes, decoded from paddr[2].
  typedef enum logic [0:0] {
    REG_ECHO_ID     = 1'b0,
    REG_TOTAL_LIMIT = 1'b1
  } reg_idx_t;

  // ICMP header layout.
  localparam int                HDR_BYTES      = 8;
  localparam logic [2:0]        HDR_LAST_IDX   = 3'd7;
  localparam logic [BYTE_W-1:0] ICMP_ECHO_TYPE = 8'h08;
  localparam logic [BYTE_W-1:0] ICMP_ECHO_CODE = 8'h00;
  localparam logic [SUM_W-1:0]  ICMP_TYPE_WORD = {ICMP_ECHO_TYPE, ICMP_ECHO_CODE};

  localparam logic [LIMIT_W-1:0] TOTAL_LIMIT_RESET = 12'd2048;
  localparam logic [LIMIT_W-1:0] COUNT_MAX         = 12'hFFF;

endpackage

@@ rtl/core/ierb_req_if.sv @@
// Request channel: one start or payload item per handshake.
interface ierb_req_if import ierb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [SEQ_W-1:0]  seq;
  logic [BYTE_W-1:0] data_byte;
  logic              last;

  modport source (output valid, op, seq, data_byte, last, input ready);
  modport sink   (input valid, op, seq, data_byte, last, output ready);
endinterface

@@ rtl/core/ierb_res_if.sv @@
// Result channel: one message byte or one error flag per handshake.
interface ierb_res_if import ierb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OFFSET_W-1:0] byte_offset;
  logic [BYTE_W-1:0]   byte_value;
  logic                error;
  logic                end_of_message;

  modport source (output valid, byte_offset, byte_value, error, end_of_message, input ready);
  modport sink   (input valid, byte_offset, byte_value, error, end_of_message, output ready);
endinterface

@@ rtl/core/icmp_echo_request_builder_unit.sv @@
// A payload byte is registered and offered in the cycle after its request is accepted.
// Throughput: one payload request per cycle while results are taken every cycle.
// A request that ends a message holds off further input until its results drain
// (up to nine results: the payload byte, then eight header bytes or one error).
// The single result buffer sets the rate: one result per cycle while res.ready is high.
// Reset (rst, synchronous): no message open, buffer empty, echo_id 0, total_limit 2048.
module icmp_echo_request_builder_unit import ierb_pkg::*; #(
  parameter int MAX_MESSAGE = 2048
) (
  input  logic                  clk,
  input  logic                  rst,
  ierb_req_if.sink              req,
  ierb_res_if.source            res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam logic [LIMIT_W-1:0] MAX_LIMIT =
    (MAX_MESSAGE > 4095) ? 12'hFFF : LIMIT_W'(MAX_MESSAGE);

  // Configuration registers.
  logic [SUM_W-1:0]   echo_id;
  logic [LIMIT_W-1:0] total_limit;

  // Message state.
  logic               in_message;
  logic [SEQ_W-1:0]   held_sequence;
  logic [SUM_W-1:0]   running_sum;
  logic [LIMIT_W-1:0] payload_count;
  logic [BYTE_W-1:0]  pending_high_byte;
  logic               overflowed;

  // Result buffer.
  logic                byte_pending;
  logic [OFFSET_W-1:0] byte_off;
  logic [BYTE_W-1:0]   byte_val;
  logic                err_pending;
  logic                hdr_pending;
  logic [2:0]          hdr_idx;
  logic [SUM_W-1:0]    hdr_cksum;
  logic [SUM_W-1:0]    hdr_id;
  logic [SUM_W-1:0]    hdr_seq;

  // Next values of the message state.
  logic               in_message_next;
  logic [SEQ_W-1:0]   held_sequence_next;
  logic [SUM_W-1:0]   running_sum_next;
  logic [LIMIT_W-1:0] payload_count_next;
  logic [BYTE_W-1:0]  pending_high_byte_next;
  logic               overflowed_next;

  logic               cfg_write;
  logic [LIMIT_W-1:0] lim;
  logic               is_start;
  logic               emit_byte;
  logic               finish;
  logic               byte_too_big;
  logic [SUM_W-1:0]   word_term;
  logic [SUM_W-1:0]   sum_base;
  logic [SEQ_W-1:0]   seq_sel;
  logic [16:0]        pair_sum;
  logic [18:0]        wide_sum;
  logic [16:0]        fold1;
  logic [SUM_W-1:0]   fold2;
  logic               take;
  logic               final_result;
  logic               buf_done;
  logic               accept;
  logic [BYTE_W-1:0]  hdr_byte;

  // ---------------------------------------------------------------- config port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      echo_id     <= '0;
      total_limit <= TOTAL_LIMIT_RESET;
    end else if (cfg_write) begin
      case (reg_idx_t'(paddr[2]))
        REG_ECHO_ID:     echo_id     <= pwdata[SUM_W-1:0];
        REG_TOTAL_LIMIT: total_limit <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[2]))
      REG_ECHO_ID:     prdata = {{(APB_DATA_W-SUM_W){1'b0}}, echo_id};
      REG_TOTAL_LIMIT: prdata = {{(APB_DATA_W-LIMIT_W){1'b0}}, total_limit};
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- request decode
  assign lim      = (MAX_LIMIT < total_limit) ? MAX_LIMIT : total_limit;
  assign is_start = (req.op == OP_START);

  // Byte at offset 8 + count would end past the limit, or the count is saturated.
  assign byte_too_big = ({1'b0, payload_count} + 13'(HDR_BYTES + 1) > {1'b0, lim}) ||
                        (payload_count == COUNT_MAX);

  // End-around carry add of a completed big-endian byte pair.
  assign pair_sum = {1'b0, running_sum} + {1'b0, pending_high_byte, req.data_byte};

  always_comb begin
    in_message_next        = in_message;
    held_sequence_next     = held_sequence;
    running_sum_next       = running_sum;
    payload_count_next     = payload_count;
    pending_high_byte_next = pending_high_byte;
    overflowed_next        = overflowed;
    emit_byte              = 1'b0;
    finish                 = 1'b0;
    if (is_start) begin
      in_message_next        = !req.last;
      held_sequence_next     = req.seq;
      running_sum_next       = '0;
      payload_count_next     = '0;
      pending_high_byte_next = '0;
      overflowed_next        = lim < LIMIT_W'(HDR_BYTES);
      finish                 = req.last;
    end else if (in_message) begin
      if (!overflowed) begin
        if (byte_too_big) begin
          overflowed_next = 1'b1;
        end else begin
          emit_byte          = 1'b1;
          payload_count_next = payload_count + 12'd1;
          if (payload_count[0]) begin
            running_sum_next = pair_sum[15:0] + {15'b0, pair_sum[16]};
          end else begin
            pending_high_byte_next = req.data_byte;
          end
        end
      end
      finish          = req.last;
      in_message_next = !req.last;
    end
  end

  // Checksum over header and payload as one multi-operand sum; the type word is
  // never zero, so folding the wide sum matches adding the words one at a time.
  always_comb begin
    if (is_start) begin
      sum_base  = '0;
      word_term = '0;
      seq_sel   = req.seq;
    end else begin
      sum_base  = running_sum;
      seq_sel   = held_sequence;
      if (!emit_byte) begin
        word_term = '0;
      end else if (payload_count[0]) begin
        word_term = {pending_high_byte, req.data_byte};
      end else begin
        word_term = {req.data_byte, 8'h00};
      end
    end
  end

  assign wide_sum = 19'(sum_base) + 19'(word_term) + 19'(ICMP_TYPE_WORD) +
                    19'(echo_id) + 19'(seq_sel);
  assign fold1    = {1'b0, wide_sum[15:0]} + {14'b0, wide_sum[18:16]};
  assign fold2    = fold1[15:0] + {15'b0, fold1[16]};

  // ---------------------------------------------------------------- result buffer
  assign take         = res.valid && res.ready;
  assign final_result = byte_pending ? (!err_pending && !hdr_pending)
                                     : (err_pending || (hdr_pending && hdr_idx == HDR_LAST_IDX));
  assign buf_done     = take && final_result;
  assign req.ready    = !res.valid || buf_done;
  assign accept       = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_message        <= 1'b0;
      held_sequence     <= '0;
      running_sum       <= '0;
      payload_count     <= '0;
      pending_high_byte <= '0;
      overflowed        <= 1'b0;
      byte_pending      <= 1'b0;
      err_pending       <= 1'b0;
      hdr_pending       <= 1'b0;
      hdr_idx           <= '0;
    end else begin
      if (accept) begin
        in_message        <= in_message_next;
        held_sequence     <= held_sequence_next;
        running_sum       <= running_sum_next;
        payload_count     <= payload_count_next;
        pending_high_byte <= pending_high_byte_next;
        overflowed        <= overflowed_next;
        byte_pending      <= emit_byte;
        err_pending       <= finish && overflowed_next;
        hdr_pending       <= finish && !overflowed_next;
        hdr_idx           <= '0;
      end else if (take) begin
        if (byte_pending) begin
          byte_pending <= 1'b0;
        end else if (err_pending) begin
          err_pending <= 1'b0;
        end else if (hdr_idx == HDR_LAST_IDX) begin
          hdr_pending <= 1'b0;
        end else begin
          hdr_idx <= hdr_idx + 3'd1;
        end
      end
    end
  end

  // Payload registers of the buffer.
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_off  <= OFFSET_W'({1'b0, payload_count} + 13'(HDR_BYTES));
      byte_val  <= req.data_byte;
      hdr_cksum <= ~fold2;
      hdr_id    <= echo_id;
      hdr_seq   <= held_sequence_next;
    end
  end

  always_comb begin
    case (hdr_idx)
      3'd0:    hdr_byte = ICMP_ECHO_TYPE;
      3'd1:    hdr_byte = ICMP_ECHO_CODE;
      3'd2:    hdr_byte = hdr_cksum[15:8];
      3'd3:    hdr_byte = hdr_cksum[7:0];
      3'd4:    hdr_byte = hdr_id[15:8];
      3'd5:    hdr_byte = hdr_id[7:0];
      3'd6:    hdr_byte = hdr_seq[15:8];
      default: hdr_byte = hdr_seq[7:0];
    endcase
  end

  assign res.valid = byte_pending || err_pending || hdr_pending;

  always_comb begin
    res.byte_offset    = '0;
    res.byte_value     = '0;
    res.error          = 1'b0;
    res.end_of_message = 1'b0;
    if (byte_pending) begin
      res.byte_offset = byte_off;
      res.byte_value  = byte_val;
    end else if (err_pending) begin
      res.error          = 1'b1;
      res.end_of_message = 1'b1;
    end else if (hdr_pending) begin
      res.byte_offset    = OFFSET_W'(hdr_idx);
      res.byte_value     = hdr_byte;
      res.end_of_message = (hdr_idx == HDR_LAST_IDX);
    end
  end

  // ---------------------------------------------------------------- checks
  a_one_ending : assert property (@(posedge clk) disable iff (rst)
    !(err_pending && hdr_pending))
    else $error("error result and header both queued");

  a_hdr_advance : assert property (@(posedge clk) disable iff (rst)
    (take && !byte_pending && !err_pending && hdr_pending && hdr_idx != HDR_LAST_IDX)
    |=> (hdr_pending && hdr_idx == 3'($past(hdr_idx) + 3'd1)))
    else $error("header byte index did not step");

  a_eom_final : assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.end_of_message) |-> (final_result && !byte_pending))
    else $error("end of message flagged on a non-final result");

  a_err_shape : assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.error) |-> (res.byte_offset == '0 && res.byte_value == '0 &&
                                  res.end_of_message))
    else $error("error result carries data");

  a_no_accept_busy : assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |-> !req.ready)
    else $error("request taken while a result is stalled");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the ICMP echo request builder: directed and random requests.
`timescale 1ns / 1ps

module testbench;
  import ierb_pkg::*;

  localparam int unsigned MSG_CAP     = 2048;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    logic [OFFSET_W-1:0] offset;
    logic [BYTE_W-1:0]   value;
    logic                err;
    logic                eom;
  } msg_byte_t;

  logic clk;
  logic rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_W-1:0]    paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  ierb_req_if req_ch ();
  ierb_res_if res_ch ();

  icmp_echo_request_builder_unit #(
    .MAX_MESSAGE(MSG_CAP)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Predicted message state and register copies.
  bit                 msg_open  = 1'b0;
  logic [SEQ_W-1:0]   seq_held  = '0;
  logic [SUM_W-1:0]   csum_acc  = '0;
  logic [LIMIT_W-1:0] pay_count = '0;
  logic [BYTE_W-1:0]  hi_byte   = '0;
  bit                 too_big   = 1'b0;
  logic [SEQ_W-1:0]   cfg_echo_id = '0;
  logic [LIMIT_W-1:0] cfg_limit   = TOTAL_LIMIT_RESET;

  msg_byte_t   pending_bytes[$];
  msg_byte_t   want_byte;
  int unsigned fail_count    = 0;
  int unsigned useful_reqs   = 0;
  int unsigned bytes_checked = 0;
  int unsigned headers_built = 0;
  int unsigned drops_flagged = 0;
  int unsigned cycle_count   = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [SUM_W-1:0] ones_add(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = a + b;
    return s[SUM_W-1:0] + s[SUM_W];
  endfunction

  function automatic int unsigned size_cap();
    return (cfg_limit < MSG_CAP) ? cfg_limit : MSG_CAP;
  endfunction

  function automatic void push_byte(int unsigned off, logic [BYTE_W-1:0] v, logic err,
                                    logic eom);
    msg_byte_t b;
    b.offset = OFFSET_W'(off);
    b.value  = v;
    b.err    = err;
    b.eom    = eom;
    pending_bytes.push_back(b);
  endfunction

  function automatic void close_message();
    logic [SUM_W-1:0] s;
    logic [SUM_W-1:0] ck;
    msg_open = 1'b0;
    if (too_big) begin
      push_byte(0, '0, 1'b1, 1'b1);
      drops_flagged++;
      return;
    end
    s = csum_acc;
    // An odd payload leaves its last byte waiting for a zero low byte.
    if (pay_count[0]) s = ones_add(s, {hi_byte, 8'h00});
    s = ones_add(s, ICMP_TYPE_WORD);
    s = ones_add(s, cfg_echo_id);
    s = ones_add(s, seq_held);
    ck = ~s;
    push_byte(0, ICMP_ECHO_TYPE, 1'b0, 1'b0);
    push_byte(1, ICMP_ECHO_CODE, 1'b0, 1'b0);
    push_byte(2, ck[15:8], 1'b0, 1'b0);
    push_byte(3, ck[7:0], 1'b0, 1'b0);
    push_byte(4, cfg_echo_id[15:8], 1'b0, 1'b0);
    push_byte(5, cfg_echo_id[7:0], 1'b0, 1'b0);
    push_byte(6, seq_held[15:8], 1'b0, 1'b0);
    push_byte(7, seq_held[7:0], 1'b0, 1'b1);
    headers_built++;
  endfunction

  // Returns 0 when the request is ignored by the block.
  function automatic bit predict_message_bytes(logic op, logic [SEQ_W-1:0] seq,
                                               logic [BYTE_W-1:0] db, logic last);
    int unsigned off;
    if (op == OP_START) begin
      msg_open  = 1'b1;
      seq_held  = seq;
      csum_acc  = '0;
      pay_count = '0;
      hi_byte   = '0;
      too_big   = HDR_BYTES > size_cap();
      if (last) close_message();
      return 1'b1;
    end
    if (!msg_open) return 1'b0;
    if (!too_big) begin
      off = HDR_BYTES + pay_count;
      if (off + 1 > size_cap() || pay_count >= COUNT_MAX) begin
        too_big = 1'b1;
      end else begin
        push_byte(off, db, 1'b0, 1'b0);
        if (pay_count[0]) csum_acc = ones_add(csum_acc, {hi_byte, db});
        else hi_byte = db;
        pay_count = pay_count + 1'b1;
      end
    end
    if (last) close_message();
    return 1'b1;
  endfunction

  always @(negedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected result: byte_offset %0d byte_value 0x%02h error %0b",
               res_ch.byte_offset, res_ch.byte_value, res_ch.error);
        fail_count++;
      end else begin
        want_byte = pending_bytes.pop_front();
        bytes_checked++;
        if (res_ch.byte_offset !== want_byte.offset) begin
          $error("byte_offset: expected %0d, got %0d", want_byte.offset, res_ch.byte_offset);
          fail_count++;
        end
        if (res_ch.byte_value !== want_byte.value) begin
          $error("byte_value: expected 0x%02h, got 0x%02h", want_byte.value,
                 res_ch.byte_value);
          fail_count++;
        end
        if (res_ch.error !== want_byte.err) begin
          $error("error: expected %0b, got %0b", want_byte.err, res_ch.error);
          fail_count++;
        end
        if (res_ch.end_of_message !== want_byte.eom) begin
          $error("end_of_message: expected %0b, got %0b", want_byte.eom,
                 res_ch.end_of_message);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles with %0d results outstanding", cycle_count,
               pending_bytes.size());
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic send_req(logic op, logic [SEQ_W-1:0] seq, logic [BYTE_W-1:0] db,
                          logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.op        <= op;
    req_ch.seq       <= seq;
    req_ch.data_byte <= db;
    req_ch.last      <= last;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (predict_message_bytes(op, seq, db, last)) useful_reqs++;
  endtask

  // Lets the block go quiet so that registers may be touched.
  task automatic settle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic reg_write(reg_idx_t idx, logic [APB_DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_ECHO_ID) cfg_echo_id = val[SEQ_W-1:0];
    else cfg_limit = val[LIMIT_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic reg_check(reg_idx_t idx);
    logic [APB_DATA_W-1:0] got;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= PADDR_W'({idx, 2'b00});
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    if (idx == REG_ECHO_ID && got[SEQ_W-1:0] !== cfg_echo_id) begin
      $error("echo_id: expected 0x%04h, got 0x%04h", cfg_echo_id, got[SEQ_W-1:0]);
      fail_count++;
    end
    if (idx == REG_TOTAL_LIMIT && got[LIMIT_W-1:0] !== cfg_limit) begin
      $error("total_limit: expected %0d, got %0d", cfg_limit, got[LIMIT_W-1:0]);
      fail_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_payload(logic [SEQ_W-1:0] seq, int unsigned len);
    int unsigned i;
    send_req(OP_START, seq, BYTE_W'($urandom_range(255)), len == 0);
    for (i = 1; i <= len; i++) begin
      send_req(OP_DATA, SEQ_W'($urandom_range(16'hFFFF)), BYTE_W'($urandom_range(255)),
               i == len);
    end
  endtask

  task automatic test_registers();
    reg_check(REG_ECHO_ID);
    reg_check(REG_TOTAL_LIMIT);
    reg_write(REG_ECHO_ID, 32'h0000_FFFF);
    reg_write(REG_TOTAL_LIMIT, 32'd4095);
    reg_check(REG_ECHO_ID);
    reg_check(REG_TOTAL_LIMIT);
    reg_write(REG_TOTAL_LIMIT, 32'd2048);
  endtask

  task automatic test_header_and_checksum();
    // A payload request with no message open is dropped silently.
    send_req(OP_DATA, 16'h0000, 8'hFF, 1'b1);
    send_req(OP_START, 16'hFFFF, 8'h00, 1'b1);
    send_req(OP_START, 16'h0000, 8'hFF, 1'b0);
    send_req(OP_DATA, 16'hFFFF, 8'h00, 1'b0);
    send_req(OP_DATA, 16'h0000, 8'hFF, 1'b0);
    send_req(OP_DATA, 16'hFFFF, 8'h80, 1'b1);
    send_req(OP_START, 16'hA5C3, 8'h00, 1'b0);
    send_req(OP_DATA, 16'h0000, 8'hFF, 1'b0);
    send_req(OP_DATA, 16'h0000, 8'hFF, 1'b1);
    // A second start abandons the open message without a header or an error result.
    send_req(OP_START, 16'h1111, 8'h00, 1'b0);
    send_req(OP_DATA, 16'h0000, 8'h12, 1'b0);
    send_req(OP_START, 16'h2222, 8'hFF, 1'b0);
    send_req(OP_DATA, 16'h0000, 8'h34, 1'b1);
    send_req(OP_DATA, 16'hFFFF, 8'h56, 1'b0);
  endtask

  task automatic test_size_limit();
    settle();
    reg_write(REG_ECHO_ID, 32'h0000_0000);
    reg_write(REG_TOTAL_LIMIT, 32'd0);
    send_payload(16'h0001, 0);
    settle();
    reg_write(REG_TOTAL_LIMIT, 32'd7);
    send_payload(16'h0002, 2);
    settle();
    reg_write(REG_TOTAL_LIMIT, 32'd8);
    send_payload(16'h0003, 0);
    send_payload(16'h0004, 1);
    settle();
    reg_write(REG_TOTAL_LIMIT, 32'd9);
    send_payload(16'h0005, 3);
  endtask

  // The largest message that fits under the limit, then one byte more.
  task automatic test_full_size();
    settle();
    reg_write(REG_ECHO_ID, 32'h0000_BEEF);
    reg_write(REG_TOTAL_LIMIT, 32'd24);
    send_payload(16'h7E57, 24 - HDR_BYTES);
    send_payload(16'h7E58, 24 - HDR_BYTES + 1);
  endtask

  task automatic send_random_message(int unsigned max_len);
    int unsigned len;
    if ($urandom_range(99) < 12) begin
      send_req(1'($urandom_range(1)), SEQ_W'($urandom_range(16'hFFFF)),
               BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
      return;
    end
    len = ($urandom_range(3) == 0) ? $urandom_range(max_len) : $urandom_range(12);
    send_payload(SEQ_W'($urandom_range(16'hFFFF)), len);
  endtask

  task automatic run_random_phase(int send_pct, int stall_pct, logic [SEQ_W-1:0] id,
                                  logic [LIMIT_W-1:0] limit, int unsigned max_len,
                                  int unsigned req_count);
    int unsigned base;
    settle();
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    reg_write(REG_ECHO_ID, {16'h0000, id});
    reg_write(REG_TOTAL_LIMIT, {20'h00000, limit});
    base = useful_reqs;
    while (useful_reqs - base < req_count) send_random_message(max_len);
    settle();
  endtask

  task automatic test_random();
    run_random_phase(18, 65, SEQ_W'($urandom_range(16'hFFFF)),
                     LIMIT_W'($urandom_range(8, 48)), 48, 52);
    run_random_phase(18, 65, 16'hFFFF, 12'd2048, 24, 52);
    run_random_phase(65, 18, SEQ_W'($urandom_range(16'hFFFF)),
                     LIMIT_W'($urandom_range(0, 30)), 32, 52);
    run_random_phase(65, 18, 16'h0000, LIMIT_W'($urandom_range(8, 24)), 24, 52);
    run_random_phase(0, 0, SEQ_W'($urandom_range(16'hFFFF)), 12'd2048, 20, 52);
    run_random_phase(0, 0, SEQ_W'($urandom_range(16'hFFFF)),
                     LIMIT_W'($urandom_range(8, 40)), 40, 52);
  endtask

  initial begin
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.op        = OP_START;
    req_ch.seq       = '0;
    req_ch.data_byte = '0;
    req_ch.last      = 1'b0;
    res_ch.ready     = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct  = 18;
    recv_stall_pct = 65;
    test_registers();
    test_header_and_checksum();
    test_size_limit();
    test_full_size();
    test_random();

    $display("Sent %0d requests that reached the builder; checked %0d result bytes.",
             useful_reqs, bytes_checked);
    $display("Built %0d headers and saw %0d oversize drops over limits from 0 to 2048.",
             headers_built, drops_flagged);
    if (fail_count == 0 && pending_bytes.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/ierb_pkg.sv
rtl/core/ierb_req_if.sv
rtl/core/ierb_res_if.sv
rtl/core/icmp_echo_request_builder_unit.sv
tb/testbench.sv
